>>> hw/rtl/sensor_maf_fir_iir_filter_bank_defines.svh
// Assertion shorthands used by the filter bank top module.
`ifndef SENSOR_MAF_FIR_IIR_FILTER_BANK_DEFINES_SVH
`define SENSOR_MAF_FIR_IIR_FILTER_BANK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sfb_pkg.sv
`timescale 1ns / 1ps

package sfb_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 16;
  localparam int AVG_BITS    = 18;
  localparam int FILT_BITS   = 20;
  localparam int COEF_BITS   = 16;

  // Configuration port
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_4 = 3'd7;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [AVG_BITS-1:0]    avg_t;
  typedef logic signed [FILT_BITS-1:0]   filt_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // ff[k]: weight on sample k back; fb[k]: weight on output k+1 back
  typedef struct packed {
    coef_t [3:0] ff;
    coef_t [3:0] fb;
  } coef_set_t;

  // Reset coefficients, Q1.15
  localparam coef_t FF_COEF_0_RST = -16'sd43;
  localparam coef_t FF_COEF_1_RST = 16'sd865;
  localparam coef_t FF_COEF_2_RST = 16'sd5105;
  localparam coef_t FF_COEF_3_RST = 16'sd10460;
  localparam coef_t FB_COEF_1_RST = 16'sd10460;
  localparam coef_t FB_COEF_2_RST = 16'sd5105;
  localparam coef_t FB_COEF_3_RST = 16'sd865;
  localparam coef_t FB_COEF_4_RST = -16'sd43;

  // Fixed FIR taps, Q1.15 (0.0350 outer, 0.4650 inner)
  localparam coef_t FIR_OUTER = 16'sd1147;
  localparam coef_t FIR_INNER = 16'sd15237;

  // Rounding to two fraction bits
  localparam int FIR_ROUND = 4096;
  localparam int FIR_SHIFT = 13;
  localparam int IIR_ROUND = 16384;
  localparam int IIR_SHIFT = 15;

endpackage

>>> hw/rtl/sfb_if.sv
`timescale 1ns / 1ps

// Sample channel
interface sfb_in_if
  import sfb_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// Result channel
interface sfb_out_if
  import sfb_pkg::*;
();
  logic  valid;
  logic  ready;
  avg_t  avg_out;
  filt_t fir_out;
  filt_t iir_out;

  modport source (output valid, output avg_out, output fir_out, output iir_out,
                  input ready);
  modport sink   (input valid, input avg_out, input fir_out, input iir_out,
                  output ready);
endinterface

>>> hw/rtl/sfb_cfg_regs.sv
`timescale 1ns / 1ps

module sfb_cfg_regs
  import sfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [CFG_IDX_W-1:0] index,
  input  coef_t                data,
  output coef_set_t            coefs
);

  // Coefficient register file
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.ff[0] <= FF_COEF_0_RST;
      coefs.ff[1] <= FF_COEF_1_RST;
      coefs.ff[2] <= FF_COEF_2_RST;
      coefs.ff[3] <= FF_COEF_3_RST;
      coefs.fb[0] <= FB_COEF_1_RST;
      coefs.fb[1] <= FB_COEF_2_RST;
      coefs.fb[2] <= FB_COEF_3_RST;
      coefs.fb[3] <= FB_COEF_4_RST;
    end else if (we) begin
      unique case (index)
        REG_FF_COEF_0: coefs.ff[0] <= data;
        REG_FF_COEF_1: coefs.ff[1] <= data;
        REG_FF_COEF_2: coefs.ff[2] <= data;
        REG_FF_COEF_3: coefs.ff[3] <= data;
        REG_FB_COEF_1: coefs.fb[0] <= data;
        REG_FB_COEF_2: coefs.fb[1] <= data;
        REG_FB_COEF_3: coefs.fb[2] <= data;
        REG_FB_COEF_4: coefs.fb[3] <= data;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/sfb_fir_avg.sv
`timescale 1ns / 1ps

module sfb_fir_avg
  import sfb_pkg::*;
(
  input  sample_t [3:0] x,     // x[0] newest
  output avg_t          avg,
  output filt_t         fir
);

  localparam int AVG_SUM_W = (SAMPLE_BITS + 2 > AVG_BITS) ? SAMPLE_BITS + 2 : AVG_BITS;
  localparam int PAIR_W    = SAMPLE_BITS + 1;
  localparam int PROD_W    = PAIR_W + COEF_BITS;
  localparam int FIR_ACC_W = PROD_W + 1;

  localparam logic signed [AVG_SUM_W-1:0] AVG_MAX =
    {{(AVG_SUM_W - AVG_BITS + 1){1'b0}}, {(AVG_BITS - 1){1'b1}}};
  localparam logic signed [AVG_SUM_W-1:0] AVG_MIN = ~AVG_MAX;
  localparam logic signed [FIR_ACC_W-1:0] FIR_MAX =
    {{(FIR_ACC_W - FILT_BITS + 1){1'b0}}, {(FILT_BITS - 1){1'b1}}};
  localparam logic signed [FIR_ACC_W-1:0] FIR_MIN = ~FIR_MAX;

  logic signed [AVG_SUM_W-1:0] avg_sum;
  logic signed [PAIR_W-1:0]    pair_outer;
  logic signed [PAIR_W-1:0]    pair_inner;
  logic signed [PROD_W-1:0]    prod_outer;
  logic signed [PROD_W-1:0]    prod_inner;
  logic signed [FIR_ACC_W-1:0] fir_acc;
  logic signed [FIR_ACC_W-1:0] fir_scaled;

  // Four-sample sum, saturated
  always_comb begin
    avg_sum = AVG_SUM_W'(x[0]) + AVG_SUM_W'(x[1]) + AVG_SUM_W'(x[2]) + AVG_SUM_W'(x[3]);
    if (avg_sum > AVG_MAX)      avg = AVG_MAX[AVG_BITS-1:0];
    else if (avg_sum < AVG_MIN) avg = AVG_MIN[AVG_BITS-1:0];
    else                        avg = avg_sum[AVG_BITS-1:0];
  end

  // Symmetric taps: fold pairs, then one multiply per pair
  always_comb begin
    pair_outer = PAIR_W'(x[0]) + PAIR_W'(x[3]);
    pair_inner = PAIR_W'(x[1]) + PAIR_W'(x[2]);
    prod_outer = pair_outer * FIR_OUTER;
    prod_inner = pair_inner * FIR_INNER;
    fir_acc    = FIR_ACC_W'(prod_outer) + FIR_ACC_W'(prod_inner)
               + FIR_ACC_W'(FIR_ROUND);
    fir_scaled = fir_acc >>> FIR_SHIFT;
    if (fir_scaled > FIR_MAX)      fir = FIR_MAX[FILT_BITS-1:0];
    else if (fir_scaled < FIR_MIN) fir = FIR_MIN[FILT_BITS-1:0];
    else                           fir = fir_scaled[FILT_BITS-1:0];
  end

endmodule

>>> hw/rtl/sfb_iir.sv
`timescale 1ns / 1ps

module sfb_iir
  import sfb_pkg::*;
(
  input  sample_t [3:0] x,      // x[0] newest sample
  input  filt_t   [3:0] hist,   // hist[0] previous output
  input  coef_set_t     coefs,
  output filt_t         iir
);

  localparam int FF_PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int FB_PROD_W = COEF_BITS + FILT_BITS;
  localparam int ACC_BASE  = (FF_PROD_W + 4 > FB_PROD_W + 2) ? FF_PROD_W + 4 : FB_PROD_W + 2;
  localparam int IIR_ACC_W = ACC_BASE + 1;

  localparam logic signed [IIR_ACC_W-1:0] IIR_MAX =
    {{(IIR_ACC_W - FILT_BITS + 1){1'b0}}, {(FILT_BITS - 1){1'b1}}};
  localparam logic signed [IIR_ACC_W-1:0] IIR_MIN = ~IIR_MAX;

  logic signed [FF_PROD_W-1:0] ff_prod [4];
  logic signed [FB_PROD_W-1:0] fb_prod [4];
  logic signed [IIR_ACC_W-1:0] ff_sum;
  logic signed [IIR_ACC_W-1:0] fb_sum;
  logic signed [IIR_ACC_W-1:0] acc;
  logic signed [IIR_ACC_W-1:0] scaled;

  // Feedforward and feedback products
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ff_prod[k] = coefs.ff[k] * x[k];
      fb_prod[k] = coefs.fb[k] * hist[k];
    end
  end

  // Feedforward is in units of 2^-15, feedback in 2^-17: align by four
  always_comb begin
    ff_sum = IIR_ACC_W'(ff_prod[0]) + IIR_ACC_W'(ff_prod[1])
           + IIR_ACC_W'(ff_prod[2]) + IIR_ACC_W'(ff_prod[3]);
    fb_sum = IIR_ACC_W'(fb_prod[0]) + IIR_ACC_W'(fb_prod[1])
           + IIR_ACC_W'(fb_prod[2]) + IIR_ACC_W'(fb_prod[3]);
    acc    = (ff_sum <<< 2) + fb_sum + IIR_ACC_W'(IIR_ROUND);
    scaled = acc >>> IIR_SHIFT;
    if (scaled > IIR_MAX)      iir = IIR_MAX[FILT_BITS-1:0];
    else if (scaled < IIR_MIN) iir = IIR_MIN[FILT_BITS-1:0];
    else                       iir = scaled[FILT_BITS-1:0];
  end

endmodule

>>> hw/rtl/sensor_maf_fir_iir_filter_bank.sv
`timescale 1ns / 1ps
// Channel   Direction  Word
// samples   in         sample_in
// results   out        avg_out, fir_out, iir_out
// cfg_*     in         cfg_index selects coefficient, cfg_data written when cfg_we
//
// One word per cycle sustained while results are taken; a sample moves from the
// input register to the result register. The IIR feedback (eight products, sum,
// round, saturate) closes between the two registers; that path sets the clock.
// Synchronous reset clears both histories and the valid flags, and reloads the
// default coefficients.
// A stalled result holds the input register; a new sample is taken whenever the
// input register is empty or moves on in the same cycle.
`include "sensor_maf_fir_iir_filter_bank_defines.svh"

module sensor_maf_fir_iir_filter_bank
  import sfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  coef_t                cfg_data,
  sfb_in_if.sink               samples,
  sfb_out_if.source            results
);

  coef_set_t       coefs;
  sample_t         sample_reg;
  logic            s1_valid;
  logic            out_valid;
  logic            advance;
  sample_t [2:0]   sample_hist;
  filt_t   [3:0]   out_hist;
  sample_t [3:0]   x;
  avg_t            avg_calc;
  filt_t           fir_calc;
  filt_t           iir_calc;
  avg_t            avg_reg;
  filt_t           fir_reg;
  filt_t           iir_reg;

  sfb_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .coefs (coefs)
  );

  // Handshake
  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;
  assign results.valid = out_valid;
  assign results.avg_out = avg_reg;
  assign results.fir_out = fir_reg;
  assign results.iir_out = iir_reg;

  // Tap vector, newest first
  assign x = {sample_hist, sample_reg};

  sfb_fir_avg u_fir_avg (
    .x   (x),
    .avg (avg_calc),
    .fir (fir_calc)
  );

  sfb_iir u_iir (
    .x     (x),
    .hist  (out_hist),
    .coefs (coefs),
    .iir   (iir_calc)
  );

  // Control and history
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      sample_hist <= '0;
      out_hist    <= '0;
    end else begin
      if (samples.valid && samples.ready) s1_valid <= 1'b1;
      else if (advance)                   s1_valid <= 1'b0;

      if (advance)            out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;

      if (advance) begin
        sample_hist <= {sample_hist[1:0], sample_reg};
        out_hist    <= {out_hist[2:0], iir_calc};
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) sample_reg <= samples.sample_in;
    if (advance) begin
      avg_reg <= avg_calc;
      fir_reg <= fir_calc;
      iir_reg <= iir_calc;
    end
  end

  // Checks
  `SFB_ASSERT_NXT(a_s1_kept, clk, rst, s1_valid && !advance, s1_valid, "input word lost")
  `SFB_ASSERT_NXT(a_result_load, clk, rst, advance, out_valid, "advanced word missing")
  `SFB_ASSERT_IMP(a_iir_hist, clk, rst, out_valid, iir_reg == out_hist[0], "iir not in history")
  `SFB_ASSERT_NXT(a_hist_hold, clk, rst, !advance, $stable(out_hist), "history moved idle")

endmodule

>>> bench/tb_sensor_maf_fir_iir_filter_bank.sv
`timescale 1ns / 1ps

module tb_sensor_maf_fir_iir_filter_bank;
  import sfb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 120;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    avg_t  avg_out;
    filt_t fir_out;
    filt_t iir_out;
  } filt_word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  coef_t                cfg_data;

  sfb_in_if  sample_ch ();
  sfb_out_if result_ch ();

  sensor_maf_fir_iir_filter_bank i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  // Filter model state
  coef_t   coef_mdl [NUM_REGS];
  longint  x_hist [3];
  longint  y_hist [4];

  sample_t    sample_q [$];
  filt_word_t filt_expect_q [$];

  int  n_pushed;
  int  n_checked;
  int  n_errors;
  int  n_cycles;
  bit  sample_taken;
  bit  no_idle;
  int  send_gap;
  int  stall_left;

  // Clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One step of the filter bank; advances the model histories
  function automatic filt_word_t filter_step(sample_t x_new);
    longint     x0;
    longint     sum;
    longint     fir;
    longint     ff;
    longint     fb;
    longint     iir;
    filt_word_t w;
    x0  = longint'(x_new);
    sum = clamp(x0 + x_hist[0] + x_hist[1] + x_hist[2], AVG_BITS);
    fir = longint'(FIR_OUTER) * (x0 + x_hist[2])
        + longint'(FIR_INNER) * (x_hist[0] + x_hist[1]);
    fir = clamp((fir + FIR_ROUND) >>> FIR_SHIFT, FILT_BITS);
    ff  = longint'(coef_mdl[REG_FF_COEF_0]) * x0
        + longint'(coef_mdl[REG_FF_COEF_1]) * x_hist[0]
        + longint'(coef_mdl[REG_FF_COEF_2]) * x_hist[1]
        + longint'(coef_mdl[REG_FF_COEF_3]) * x_hist[2];
    fb  = longint'(coef_mdl[REG_FB_COEF_1]) * y_hist[0]
        + longint'(coef_mdl[REG_FB_COEF_2]) * y_hist[1]
        + longint'(coef_mdl[REG_FB_COEF_3]) * y_hist[2]
        + longint'(coef_mdl[REG_FB_COEF_4]) * y_hist[3];
    iir = clamp((ff * 4 + fb + IIR_ROUND) >>> IIR_SHIFT, FILT_BITS);
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x0;
    y_hist[3] = y_hist[2];
    y_hist[2] = y_hist[1];
    y_hist[1] = y_hist[0];
    y_hist[0] = iir;
    w.avg_out = avg_t'(sum);
    w.fir_out = filt_t'(fir);
    w.iir_out = filt_t'(iir);
    return w;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return sample_t'($urandom_range(0, 15) - 8);
    return sample_t'($urandom);
  endfunction

  function automatic coef_t rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return '0;
    return coef_t'($urandom);
  endfunction

  function automatic void report(string what, longint exp_v, longint act_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endfunction

  // Sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!sample_ch.valid || sample_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        sample_ch.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        sample_ch.sample_in <= sample_q.pop_front();
        sample_ch.valid     <= 1'b1;
        send_gap = pick_gap();
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Model update, prediction and result check
  always @(posedge clk) begin
    filt_word_t got;
    filt_word_t want;
    if (rst) begin
      coef_mdl[REG_FF_COEF_0] = FF_COEF_0_RST;
      coef_mdl[REG_FF_COEF_1] = FF_COEF_1_RST;
      coef_mdl[REG_FF_COEF_2] = FF_COEF_2_RST;
      coef_mdl[REG_FF_COEF_3] = FF_COEF_3_RST;
      coef_mdl[REG_FB_COEF_1] = FB_COEF_1_RST;
      coef_mdl[REG_FB_COEF_2] = FB_COEF_2_RST;
      coef_mdl[REG_FB_COEF_3] = FB_COEF_3_RST;
      coef_mdl[REG_FB_COEF_4] = FB_COEF_4_RST;
      foreach (x_hist[k]) x_hist[k] = 0;
      foreach (y_hist[k]) y_hist[k] = 0;
      sample_taken <= 1'b0;
    end else begin
      if (cfg_we)
        coef_mdl[cfg_index] = cfg_data;
      sample_taken <= sample_ch.valid && sample_ch.ready;
      if (sample_ch.valid && sample_ch.ready)
        filt_expect_q.push_back(filter_step(sample_ch.sample_in));
      if (result_ch.valid && result_ch.ready) begin
        n_checked++;
        got.avg_out = result_ch.avg_out;
        got.fir_out = result_ch.fir_out;
        got.iir_out = result_ch.iir_out;
        if (filt_expect_q.size() == 0) begin
          report("unexpected word avg_out", 0, got.avg_out);
        end else begin
          want = filt_expect_q.pop_front();
          if (got.avg_out !== want.avg_out) report("avg_out", want.avg_out, got.avg_out);
          if (got.fir_out !== want.fir_out) report("fir_out", want.fir_out, got.fir_out);
          if (got.iir_out !== want.iir_out) report("iir_out", want.iir_out, got.iir_out);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("tb_sensor_maf_fir_iir_filter_bank: done, errors");
      $finish;
    end
  end

  task automatic push_sample(sample_t v);
    sample_q.push_back(v);
    n_pushed++;
  endtask

  // Hold the sender until every word has come back
  task automatic drain();
    do @(negedge clk); while (n_checked < n_pushed);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, coef_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
  endtask

  task automatic write_all(coef_t ff0, coef_t ff1, coef_t ff2, coef_t ff3,
                           coef_t fb1, coef_t fb2, coef_t fb3, coef_t fb4);
    write_coef(REG_FF_COEF_0, ff0);
    write_coef(REG_FF_COEF_1, ff1);
    write_coef(REG_FF_COEF_2, ff2);
    write_coef(REG_FF_COEF_3, ff3);
    write_coef(REG_FB_COEF_1, fb1);
    write_coef(REG_FB_COEF_2, fb2);
    write_coef(REG_FB_COEF_3, fb3);
    write_coef(REG_FB_COEF_4, fb4);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    int      n_run;
    sample_t v;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.sample_in = '0;
    result_ch.ready     = 1'b0;
    n_pushed  = 0;
    n_checked = 0;
    n_errors  = 0;
    n_cycles  = 0;
    no_idle   = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients: zero, unit steps, both full-scale extremes
    push_sample(16'sd0);
    push_sample(16'sd1);
    push_sample(-16'sd1);
    repeat (4) push_sample(16'sh7fff);
    repeat (4) push_sample(16'sh8000);
    push_sample(16'sh5555);
    push_sample(16'shaaaa);
    push_sample(16'sd0);
    drain();

    // Full-scale coefficients drive the IIR into saturation
    write_all(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    repeat (4) push_sample(16'sh7fff);
    repeat (5) push_sample(16'sh8000);
    drain();

    // Random phases, a new coefficient set each time
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: write_all(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        1: write_all(FF_COEF_0_RST, FF_COEF_1_RST, FF_COEF_2_RST, FF_COEF_3_RST,
                     '0, '0, '0, '0);
        default: write_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                           rand_coef(), rand_coef(), rand_coef(), rand_coef());
      endcase
      no_idle = (p == 2);
      @(posedge clk);
      n_run = 0;
      while (n_run < PHASE_ITEMS) begin
        // occasional constant runs fill the history with one value
        if ($urandom_range(0, 9) == 0) begin
          v = rand_sample();
          repeat ($urandom_range(4, 10)) begin
            push_sample(v);
            n_run++;
          end
        end else begin
          push_sample(rand_sample());
          n_run++;
        end
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (10) @(negedge clk);
    while (filt_expect_q.size() > 0) begin
      report("missing word avg_out", filt_expect_q[0].avg_out, 0);
      void'(filt_expect_q.pop_front());
    end
    if (n_errors == 0) begin
      $display("tb_sensor_maf_fir_iir_filter_bank: done, clean");
    end else begin
      $display("tb_sensor_maf_fir_iir_filter_bank: done, errors");
    end
    $finish;
  end

endmodule
